### hdl/frla_pkg.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster package
// Shared widths, input mode codes, register indexes and the command and
// status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package frla_pkg;

	localparam int LINE_W   = 9;
	localparam int LINES_W  = 6;
	localparam int TARGET_W = 48;
	localparam int ERR_W    = 64;
	localparam int GAP_W    = TARGET_W + 1;
	localparam int MODE_W   = 2;
	localparam int CFG_IW   = 1;

	// Input mode codes.
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] REG_TARGET = 1'b0;
	localparam logic [CFG_IW-1:0] REG_SKIP   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic prep;
		logic gap_slow;
		logic clr_err;
		logic add_gap;
		logic drain_step;
		logic clr_lines;
		logic load_out;
		logic out_slow;
		logic out_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic               in_valid;
		logic [MODE_W-1:0]  mode;
		logic               target_eq;
		logic               target_ge;
		logic               err_ge_half;
		logic [LINES_W-1:0] lines;
		logic [LINES_W-1:0] skip_eff;
		logic               out_free;
	} sts_t;

endpackage

### hdl/frla_in_if.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster input channel
// Valid/ready channel that carries one event word.
// ----------------------------------------------------------------------------
interface frla_in_if;
	logic                          valid;
	logic                          ready;
	logic [frla_pkg::MODE_W-1:0]   mode;
	logic [frla_pkg::LINE_W-1:0]   current_line;

	modport source (output valid, output mode, output current_line, input ready);
	modport sink (input valid, input mode, input current_line, output ready);
endinterface

### hdl/frla_out_if.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster output channel
// Valid/ready channel that carries one burst word.
// ----------------------------------------------------------------------------
interface frla_out_if;
	logic                          valid;
	logic                          ready;
	logic [frla_pkg::LINE_W-1:0]   new_line;
	logic [frla_pkg::LINES_W-1:0]  lines_moved;
	logic                          last;

	modport source (output valid, output new_line, output lines_moved, output last,
		input ready);
	modport sink (input valid, input new_line, input lines_moved, input last,
		output ready);
endinterface

### hdl/frla_datapath.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster datapath
// Configuration registers, gap computation, saturating cycle accumulator,
// line drain step and the output word register.
// ----------------------------------------------------------------------------
module frla_datapath #(
	parameter int FRAME_CYCLES = 560190,
	parameter int LINE_CYCLES  = 2130
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frla_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [frla_pkg::TARGET_W-1:0]   cfg_data,
	frla_in_if.sink                         in_item,
	frla_out_if.source                      out_item,
	input  frla_pkg::cmd_t                  cmd,
	output frla_pkg::sts_t                  sts
);

	localparam logic [frla_pkg::TARGET_W-1:0] NATIVE_FX =
		frla_pkg::TARGET_W'(FRAME_CYCLES) << 24;
	localparam logic signed [frla_pkg::ERR_W-1:0] FULL_LINE =
		frla_pkg::ERR_W'(LINE_CYCLES) << 24;
	localparam logic signed [frla_pkg::ERR_W-1:0] HALF_LINE =
		frla_pkg::ERR_W'(LINE_CYCLES) << 23;
	localparam logic signed [frla_pkg::ERR_W-1:0] ERR_MAX =
		{1'b0, {(frla_pkg::ERR_W-1){1'b1}}};
	localparam logic signed [frla_pkg::ERR_W-1:0] ERR_MIN =
		{1'b1, {(frla_pkg::ERR_W-1){1'b0}}};

	logic [frla_pkg::TARGET_W-1:0]       target_q;
	logic [frla_pkg::LINES_W-1:0]        skip_q;
	logic [frla_pkg::MODE_W-1:0]         mode_q;
	logic [frla_pkg::LINE_W-1:0]         cur_q;
	logic signed [frla_pkg::GAP_W-1:0]   gap_q;
	logic                                eq_q;
	logic                                ge_q;
	logic signed [frla_pkg::ERR_W-1:0]   err_q;
	logic [frla_pkg::LINES_W-1:0]        lines_q;
	logic                                out_valid_q;
	logic [frla_pkg::LINE_W-1:0]         out_line_q;
	logic [frla_pkg::LINES_W-1:0]        out_lines_q;
	logic                                out_last_q;

	logic signed [frla_pkg::GAP_W-1:0]   diff;
	logic signed [frla_pkg::GAP_W-1:0]   ndiff;
	logic signed [frla_pkg::ERR_W-1:0]   gap_ext;
	logic signed [frla_pkg::ERR_W-1:0]   sum;
	logic signed [frla_pkg::ERR_W-1:0]   sat_sum;
	logic                                ovf;
	logic [frla_pkg::LINE_W-1:0]         line_back;
	logic [frla_pkg::LINE_W-1:0]         line_fwd;
	logic                                take;
	logic                                out_free;

	// Input handshake.
	assign in_item.ready = cmd.in_ready;
	assign take          = in_item.valid && cmd.in_ready;

	// Gap between target and native frame length, in both directions.
	assign diff  = $signed({1'b0, target_q}) - $signed({1'b0, NATIVE_FX});
	assign ndiff = $signed({1'b0, NATIVE_FX}) - $signed({1'b0, target_q});

	// Saturating add of the gap into the accumulator.
	assign gap_ext = {{(frla_pkg::ERR_W-frla_pkg::GAP_W){gap_q[frla_pkg::GAP_W-1]}}, gap_q};
	assign sum     = err_q + gap_ext;
	assign ovf     = (err_q[frla_pkg::ERR_W-1] == gap_ext[frla_pkg::ERR_W-1]) &&
		(sum[frla_pkg::ERR_W-1] != err_q[frla_pkg::ERR_W-1]);
	assign sat_sum = ovf ? (err_q[frla_pkg::ERR_W-1] ? ERR_MIN : ERR_MAX) : sum;

	// Rewritten line values for both directions.
	assign line_back = cur_q - frla_pkg::LINE_W'(lines_q) + frla_pkg::LINE_W'(1);
	assign line_fwd  = cur_q + frla_pkg::LINE_W'(lines_q) + frla_pkg::LINE_W'(1);

	assign out_free = !out_valid_q || out_item.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= NATIVE_FX;
			skip_q   <= frla_pkg::LINES_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				frla_pkg::REG_TARGET: target_q <= cfg_data;
				frla_pkg::REG_SKIP:   skip_q   <= cfg_data[frla_pkg::LINES_W-1:0];
				default: ;
			endcase
		end
	end

	// Event word, gap and flags from the configuration.
	always_ff @(posedge clk) begin
		if (take) begin
			mode_q <= in_item.mode;
			cur_q  <= in_item.current_line;
		end
		if (cmd.prep) begin
			gap_q <= cmd.gap_slow ? diff : ndiff;
			eq_q  <= (target_q == NATIVE_FX);
			ge_q  <= !diff[frla_pkg::GAP_W-1];
		end
	end

	// Cycle accumulator and drained line count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= '0;
			lines_q <= '0;
		end else begin
			if (cmd.clr_err) begin
				err_q <= '0;
			end else if (cmd.add_gap) begin
				err_q <= sat_sum;
			end else if (cmd.drain_step) begin
				err_q <= err_q - FULL_LINE;
			end
			if (cmd.clr_lines) begin
				lines_q <= '0;
			end else if (cmd.drain_step) begin
				lines_q <= lines_q + frla_pkg::LINES_W'(1);
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_line_q  <= cmd.out_slow ? line_back : line_fwd;
			out_lines_q <= lines_q;
			out_last_q  <= cmd.out_last;
		end
	end

	assign out_item.valid       = out_valid_q;
	assign out_item.new_line    = out_line_q;
	assign out_item.lines_moved = out_lines_q;
	assign out_item.last        = out_last_q;

	// Status toward the controller.
	always_comb begin
		sts.in_valid    = in_item.valid;
		sts.mode        = mode_q;
		sts.target_eq   = eq_q;
		sts.target_ge   = ge_q;
		sts.err_ge_half = (err_q >= HALF_LINE);
		sts.lines       = lines_q;
		sts.skip_eff    = (skip_q == '0) ? frla_pkg::LINES_W'(1) : skip_q;
		sts.out_free    = out_free;
	end

endmodule

### hdl/frla_ctrl.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster controller
// Sequences start, stop and tick events, the gap add, the line drain loop
// and the burst emission, and keeps the adjustment mode flags.
// ----------------------------------------------------------------------------
module frla_ctrl #(
	parameter int SLOW_BURST_LINES = 5,
	parameter int MAX_BURSTS       = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  frla_pkg::sts_t sts,
	output frla_pkg::cmd_t cmd
);

	localparam int BURST_W = $clog2(MAX_BURSTS + 1);
	localparam logic [BURST_W-1:0] BURST_LAST = BURST_W'(MAX_BURSTS - 1);
	localparam logic [frla_pkg::LINES_W-1:0] SLOW_LIMIT =
		frla_pkg::LINES_W'(SLOW_BURST_LINES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DISPATCH,
		ST_ADD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 running_q;
	logic                 first_q;
	logic                 slow_q;
	logic                 back_q;
	logic [BURST_W-1:0]   burst_q;

	logic [frla_pkg::LINES_W-1:0] limit;
	logic                         at_limit;
	logic                         cap;
	logic                         last;

	assign limit    = slow_q ? SLOW_LIMIT : sts.skip_eff;
	assign at_limit = (sts.lines + frla_pkg::LINES_W'(1)) == limit;
	assign cap      = (burst_q == BURST_LAST);
	// A slow burst is the final one when the cap is reached or no half line is left.
	assign last     = !slow_q || cap || !sts.err_ge_half;

	// State and mode flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			first_q   <= 1'b0;
			slow_q    <= 1'b0;
			back_q    <= 1'b0;
			burst_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sts.in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					state_q <= ST_IDLE;
					case (sts.mode)
						frla_pkg::MODE_START: begin
							if (!running_q && !sts.target_eq) begin
								back_q    <= 1'b0;
								first_q   <= 1'b1;
								slow_q    <= sts.target_ge;
								running_q <= 1'b1;
							end
						end
						frla_pkg::MODE_STOP: begin
							running_q <= 1'b0;
						end
						frla_pkg::MODE_TICK: begin
							if (running_q) begin
								if (first_q) begin
									first_q <= 1'b0;
								end else begin
									burst_q <= '0;
									state_q <= (slow_q && back_q) ? ST_DRAIN : ST_ADD;
								end
							end
						end
						default: ;
					endcase
				end
				ST_ADD: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (sts.err_ge_half) begin
						if (at_limit) begin
							state_q <= ST_EMIT;
						end
					end else if (sts.lines != '0) begin
						state_q <= ST_EMIT;
					end else begin
						if (slow_q) begin
							back_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (slow_q) begin
							back_q <= last ? (cap && (sts.lines > frla_pkg::LINES_W'(1))) : 1'b1;
						end
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							burst_q <= burst_q + BURST_W'(1);
							state_q <= ST_DRAIN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.gap_slow = slow_q;
		cmd.out_slow = slow_q;
		cmd.out_last = last;
		case (state_q)
			ST_IDLE:     cmd.in_ready = 1'b1;
			ST_PREP:     cmd.prep = 1'b1;
			ST_DISPATCH: begin
				cmd.clr_lines = 1'b1;
				cmd.clr_err   = (sts.mode == frla_pkg::MODE_START) && !running_q &&
					!sts.target_eq;
			end
			ST_ADD:      cmd.add_gap = 1'b1;
			ST_DRAIN:    cmd.drain_step = sts.err_ge_half;
			ST_EMIT: begin
				cmd.load_out  = sts.out_free;
				cmd.clr_lines = sts.out_free && !last;
			end
			default: ;
		endcase
	end

endmodule

### hdl/frame_rate_line_adjuster_top.sv
// ----------------------------------------------------------------------------
// Frame rate line adjuster
// Start, stop and unused words, ticks while stopped and the first tick pass
// only the prep and dispatch states. Any other tick then does the gap add,
// skipped after a back jump, and per burst one 64-bit accumulator drain step
// per drained line, one more drain check when the drain ends below half a line,
// and the output load once the output is free. One word is handled at a time.
// Reset clears all flags and the accumulator and loads the native frame length.
// ----------------------------------------------------------------------------
module frame_rate_line_adjuster_top #(
	parameter int FRAME_CYCLES     = 560190,
	parameter int LINE_CYCLES      = 2130,
	parameter int SLOW_BURST_LINES = 5,
	parameter int MAX_BURSTS       = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [frla_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [frla_pkg::TARGET_W-1:0] cfg_data,
	frla_in_if.sink                       in_item,
	frla_out_if.source                    out_item
);

	frla_pkg::cmd_t cmd;
	frla_pkg::sts_t sts;

	// Controller.
	frla_ctrl #(
		.SLOW_BURST_LINES (SLOW_BURST_LINES),
		.MAX_BURSTS       (MAX_BURSTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath.
	frla_datapath #(
		.FRAME_CYCLES (FRAME_CYCLES),
		.LINE_CYCLES  (LINE_CYCLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

	// One word is in work at a time.
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_item.valid && in_item.ready) |=> !in_item.ready)
		else $error("input taken while a word is in work");

	// A burst always moves at least one line.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid |-> (out_item.lines_moved != '0))
		else $error("burst with no lines");

	// A fast mode burst is always the only one of its tick.
	a_fast_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !cmd.out_slow) |-> cmd.out_last)
		else $error("fast burst not marked last");

endmodule
